### rtl/tsfi_pkg.sv
// shared types, constants and helpers of the timestamp fix and interleave unit
`default_nettype none
package tsfi_pkg;

	localparam int NUM_STREAMS_DEF = 4;
	localparam int HOLD_DEPTH_DEF  = 64;
	localparam int TS_W            = 64;
	localparam int TAG_W           = 16;
	localparam int SID_FIELD_W     = 2;
	localparam int SCALE_W         = 20;
	localparam int LIMIT_W         = 6;
	localparam int CFG_IDX_W       = 3;
	localparam int STATUS_W        = 3;
	localparam int S_DATA_W        = 144;
	localparam int S_USER_W        = 3;
	localparam int M_DATA_W        = 144;
	localparam int M_USER_W        = 7;

	localparam logic [TS_W-1:0] TS_MIN = {1'b1, {(TS_W-1){1'b0}}};
	localparam logic [TS_W-1:0] TS_MAX = {1'b0, {(TS_W-1){1'b1}}};

	typedef enum logic [STATUS_W-1:0] {
		ST_HELD     = 3'd0,
		ST_SHIFTED  = 3'd1,
		ST_DUP      = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_REJECT   = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OPEN  = 3'd0,
		CFG_LIMIT = 3'd1,
		CFG_NUM1  = 3'd2,
		CFG_DEN1  = 3'd3,
		CFG_NUM2  = 3'd4,
		CFG_DEN2  = 3'd5,
		CFG_NUM3  = 3'd6,
		CFG_DEN3  = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_CONV,
		S_INS_RD,
		S_INS_CMP,
		S_INS_WR,
		S_LIMIT,
		S_REL_RD,
		S_REL_CHK,
		S_REL_PUSH,
		S_FINISH
	} state_t;

	typedef enum logic [2:0] {
		R_IDLE,
		R_NEG,
		R_MUL,
		R_SUM,
		R_DIV,
		R_RND
	} rphase_t;

	// one held packet
	typedef struct packed {
		logic [TS_W-1:0]        key;
		logic [TS_W-1:0]        dts;
		logic [TS_W-1:0]        pts;
		logic [SID_FIELD_W-1:0] sid;
		logic [TAG_W-1:0]       tag;
		logic                   kf;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic classify;
		logic key_store;
		logic ins_read;
		logic ins_move;
		logic ins_write;
		logic lim_calc;
		logic rel_read;
		logic rel_take;
		logic rel_push;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic go;
		logic conv_done;
		logic ins_zero;
		logic ins_less;
		logic all_seen;
		logic rel_more;
		logic rel_ok;
		logic pend_valid;
		logic out_free;
	} stat_t;

	// signed less-than on two's complement patterns
	function automatic logic lt_s(input logic [TS_W-1:0] a, input logic [TS_W-1:0] b);
		return $signed(a) < $signed(b);
	endfunction

endpackage
`default_nettype wire

### rtl/tsfi_rescale.sv
// timebase conversion: round(t * num / den) with a bit-serial divider
`default_nettype none
module tsfi_rescale
	import tsfi_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [TS_W-1:0]    t,
	input  wire logic [SCALE_W-1:0] num,
	input  wire logic [SCALE_W-1:0] den,
	input  wire logic               bypass,
	output logic                    done,
	output logic [TS_W-1:0]         res
);

	localparam int HALF_W = TS_W / 2;
	localparam int PROD_W = HALF_W + SCALE_W;
	localparam int FULL_W = TS_W + SCALE_W;
	localparam int CNT_W  = $clog2(TS_W);

	rphase_t             ph_q, ph_nxt;
	logic                neg_q, sat_q, done_q;
	logic [TS_W-1:0]     t_q, m_q, dvd_q, res_q;
	logic [SCALE_W-1:0]  n_q, d_q, rem_q;
	logic [PROD_W-1:0]   ph_prod_q, pl_prod_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [FULL_W-1:0]   full_sum;
	logic [SCALE_W:0]    trial;
	logic                take;
	logic [TS_W:0]       q_rnd;
	logic [TS_W-1:0]     q_clamp;

	// next phase
	always_comb begin
		ph_nxt = ph_q;
		case (ph_q)
			R_IDLE: if (start && !bypass) ph_nxt = R_NEG;
			R_NEG:  ph_nxt = R_MUL;
			R_MUL:  ph_nxt = R_SUM;
			R_SUM:  ph_nxt = R_DIV;
			R_DIV:  if (cnt_q == CNT_W'(TS_W - 1)) ph_nxt = R_RND;
			R_RND:  ph_nxt = R_IDLE;
			default: ph_nxt = R_IDLE;
		endcase
	end

	// arithmetic of the current phase
	always_comb begin
		full_sum = {ph_prod_q, {HALF_W{1'b0}}} + FULL_W'(pl_prod_q);
		trial    = {rem_q, dvd_q[TS_W-1]};
		take     = trial >= {1'b0, d_q};
		q_rnd    = {1'b0, dvd_q} + (TS_W+1)'({rem_q, 1'b0} >= {1'b0, d_q});
		if (!neg_q)
			q_clamp = (q_rnd > {1'b0, TS_MAX}) ? TS_MAX : q_rnd[TS_W-1:0];
		else
			q_clamp = (q_rnd > {1'b0, TS_MIN}) ? TS_MIN : q_rnd[TS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= R_IDLE;
			done_q <= 1'b0;
		end else begin
			ph_q   <= ph_nxt;
			done_q <= (ph_q == R_IDLE && start && bypass) || (ph_q == R_RND);
		end
	end

	// operand and working registers
	always_ff @(posedge clk) begin
		case (ph_q)
			R_IDLE: begin
				if (start) begin
					t_q   <= t;
					n_q   <= num;
					d_q   <= (den == '0) ? SCALE_W'(1) : den;
					neg_q <= t[TS_W-1];
					res_q <= t;
				end
			end
			R_NEG: m_q <= neg_q ? (TS_W'(0) - t_q) : t_q;
			R_MUL: begin
				ph_prod_q <= PROD_W'(m_q[TS_W-1:HALF_W]) * PROD_W'(n_q);
				pl_prod_q <= PROD_W'(m_q[HALF_W-1:0]) * PROD_W'(n_q);
			end
			R_SUM: begin
				sat_q <= ph_prod_q >= (PROD_W'(d_q) << (HALF_W - 1));
				rem_q <= full_sum[FULL_W-1:TS_W];
				dvd_q <= full_sum[TS_W-1:0];
				cnt_q <= '0;
			end
			R_DIV: begin
				rem_q <= take ? SCALE_W'(trial - {1'b0, d_q}) : trial[SCALE_W-1:0];
				dvd_q <= {dvd_q[TS_W-2:0], take};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			R_RND: begin
				if (sat_q)
					res_q <= neg_q ? TS_MIN : TS_MAX;
				else if (!neg_q)
					res_q <= q_clamp;
				else
					res_q <= TS_W'(0) - q_clamp;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

### rtl/tsfi_dp.sv
// datapath: registers, per-stream state, hold memory and result register
`default_nettype none
module tsfi_dp
	import tsfi_pkg::*;
#(
	parameter int NUM_STREAMS = NUM_STREAMS_DEF,
	parameter int HOLD_DEPTH  = HOLD_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [S_DATA_W-1:0]  s_tdata,
	input  wire logic [S_USER_W-1:0]  s_tuser,
	input  wire logic                 cfg_valid,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SCALE_W-1:0]   cfg_data,
	input  wire cmd_t                 cmd,
	output stat_t                     stat,
	output logic                      cfg_ready,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_DATA_W-1:0]       m_tdata,
	output logic [M_USER_W-1:0]       m_tuser,
	output logic                      m_tlast
);

	localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
	localparam int PTR_W = $clog2(HOLD_DEPTH);
	localparam int SID_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

	// configuration
	logic               open_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [SCALE_W-1:0] num_q [1:3];
	logic [SCALE_W-1:0] den_q [1:3];

	// captured item
	logic [SID_FIELD_W-1:0] sid_q;
	logic [TS_W-1:0]        dts_q, pts_q;
	logic [TAG_W-1:0]       tag_q;
	logic                   kf_q;

	// per-stream state
	logic [TS_W-1:0]        last_q [NUM_STREAMS];
	logic [TS_W-1:0]        lkey_q [NUM_STREAMS];
	logic [NUM_STREAMS-1:0] seen_q;

	status_t          status_q;
	logic [TS_W-1:0]  fdts_q, fpts_q, key_q, lim_q;
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q, idx_q;

	entry_t mem [HOLD_DEPTH];
	entry_t rd_q, take_q, pend_q;
	logic   pend_v_q;

	logic                   out_v_q, out_rv_q, out_last_q, out_kf_q;
	status_t                out_status_q;
	logic [SID_FIELD_W-1:0] out_sid_q;
	logic [TS_W-1:0]        out_dts_q, out_pts_q;
	logic [TAG_W-1:0]       out_tag_q;

	logic [SID_W-1:0] sidx;
	logic [TS_W-1:0]  last, fix_dts, fix_pts, lim;
	logic             sid_ok, lt, dup, shift, full, go, all_seen;
	status_t          cls_status;
	logic [SCALE_W-1:0] cv_num, cv_den;
	logic             cv_bypass, conv_done;
	logic [TS_W-1:0]  conv_res;
	logic [CNT_W-1:0] rd_idx;
	logic [PTR_W-1:0] rd_addr, wr_addr;
	logic             we;
	entry_t           wdata, new_entry;
	logic             push_out;

	// place in the circular store
	function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] h,
			input logic [CNT_W-1:0] i);
		logic [PTR_W:0] sum;
		sum = {1'b0, h} + (PTR_W+1)'(i);
		if (sum >= (PTR_W+1)'(HOLD_DEPTH))
			sum = sum - (PTR_W+1)'(HOLD_DEPTH);
		return sum[PTR_W-1:0];
	endfunction

	// classify the captured item
	always_comb begin
		sidx    = sid_q[SID_W-1:0];
		sid_ok  = open_q && ((STATUS_W)'(sid_q) < (STATUS_W)'(NUM_STREAMS));
		last    = last_q[sidx];
		lt      = lt_s(dts_q, last);
		dup     = (dts_q == last) || (lt && last == TS_MAX);
		shift   = lt && last != TS_MAX;
		full    = count_q >= CNT_W'(HOLD_DEPTH);
		fix_dts = shift ? (last + TS_W'(1)) : dts_q;
		fix_pts = shift ? (last + TS_W'(1) + (pts_q - dts_q)) : pts_q;
		if (!sid_ok)
			cls_status = ST_REJECT;
		else if (dup)
			cls_status = ST_DUP;
		else if (full)
			cls_status = ST_OVERFLOW;
		else if (shift)
			cls_status = ST_SHIFTED;
		else
			cls_status = ST_HELD;
		go = sid_ok && !dup && !full;
	end

	// conversion ratio of the stream
	always_comb begin
		cv_num    = num_q[1];
		cv_den    = den_q[1];
		cv_bypass = (fix_dts == TS_MIN) || (fix_dts == TS_MAX);
		case (sid_q)
			2'd1: begin cv_num = num_q[1]; cv_den = den_q[1]; end
			2'd2: begin cv_num = num_q[2]; cv_den = den_q[2]; end
			2'd3: begin cv_num = num_q[3]; cv_den = den_q[3]; end
			default: cv_bypass = 1'b1;
		endcase
	end

	tsfi_rescale u_rescale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.classify && go),
		.t      (fix_dts),
		.num    (cv_num),
		.den    (cv_den),
		.bypass (cv_bypass),
		.done   (conv_done),
		.res    (conv_res)
	);

	// smallest latest key over the streams
	always_comb begin
		lim = TS_MAX;
		for (int i = 0; i < NUM_STREAMS; i++)
			if (lt_s(lkey_q[i], lim)) lim = lkey_q[i];
	end

	// memory addressing
	always_comb begin
		all_seen  = &seen_q;
		rd_idx    = cmd.ins_read ? (idx_q - CNT_W'(1)) : idx_q;
		rd_addr   = phys(head_q, rd_idx);
		wr_addr   = phys(head_q, idx_q);
		new_entry = '{key: key_q, dts: fdts_q, pts: fpts_q, sid: sid_q, tag: tag_q, kf: kf_q};
		we        = cmd.ins_move || cmd.ins_write;
		wdata     = cmd.ins_move ? rd_q : new_entry;
		push_out  = (cmd.rel_push && pend_v_q) || cmd.finish;
	end

	// hold memory
	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wdata;
		if (cmd.ins_read || cmd.rel_read) rd_q <= mem[rd_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			limit_q <= '1;
			for (int i = 1; i <= 3; i++) begin
				num_q[i] <= SCALE_W'(1);
				den_q[i] <= SCALE_W'(1);
			end
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_OPEN:  open_q   <= cfg_data[0];
				CFG_LIMIT: limit_q  <= cfg_data[LIMIT_W-1:0];
				CFG_NUM1:  num_q[1] <= cfg_data;
				CFG_DEN1:  den_q[1] <= cfg_data;
				CFG_NUM2:  num_q[2] <= cfg_data;
				CFG_DEN2:  den_q[2] <= cfg_data;
				CFG_NUM3:  num_q[3] <= cfg_data;
				CFG_DEN3:  den_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// item capture and working payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sid_q <= s_tuser[SID_FIELD_W-1:0];
			kf_q  <= s_tuser[SID_FIELD_W];
			dts_q <= s_tdata[TS_W-1:0];
			pts_q <= s_tdata[2*TS_W-1:TS_W];
			tag_q <= s_tdata[2*TS_W+TAG_W-1:2*TS_W];
		end
		if (cmd.classify) begin
			status_q <= cls_status;
			fdts_q   <= fix_dts;
			fpts_q   <= fix_pts;
		end
		if (cmd.key_store) key_q <= conv_res;
		if (cmd.ins_write && !all_seen
				&& (CNT_W+LIMIT_W)'(count_q + CNT_W'(1)) > (CNT_W+LIMIT_W)'(limit_q))
			status_q <= ST_OVERFLOW;
		if (cmd.lim_calc) lim_q <= lim;
		if (cmd.rel_take) take_q <= rd_q;
		if (cmd.rel_push) pend_q <= take_q;
	end

	// per-stream state and store control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STREAMS; i++) begin
				last_q[i] <= TS_MIN;
				lkey_q[i] <= '0;
			end
			seen_q   <= '0;
			head_q   <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q    <= '0;
				pend_v_q <= 1'b0;
			end
			if (cmd.classify && go) begin
				last_q[sidx] <= fix_dts;
				seen_q[sidx] <= 1'b1;
			end
			if (cmd.key_store) begin
				lkey_q[sidx] <= conv_res;
				idx_q        <= count_q;
			end
			if (cmd.ins_move) idx_q <= idx_q - CNT_W'(1);
			if (cmd.ins_write) begin
				count_q <= count_q + CNT_W'(1);
				idx_q   <= '0;
			end
			if (cmd.rel_push) begin
				pend_v_q <= 1'b1;
				idx_q    <= idx_q + CNT_W'(1);
			end
			if (cmd.finish) begin
				head_q   <= wr_addr;
				count_q  <= count_q - idx_q;
				pend_v_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (push_out)
			out_v_q <= 1'b1;
		else if (m_tready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (push_out) begin
			out_status_q <= status_q;
			out_last_q   <= cmd.finish;
			out_rv_q     <= pend_v_q;
			out_sid_q    <= pend_v_q ? pend_q.sid : '0;
			out_dts_q    <= pend_v_q ? pend_q.dts : '0;
			out_pts_q    <= pend_v_q ? pend_q.pts : '0;
			out_tag_q    <= pend_v_q ? pend_q.tag : '0;
			out_kf_q     <= pend_v_q ? pend_q.kf : 1'b0;
		end
	end

	// status to the controller
	always_comb begin
		stat.go         = go;
		stat.conv_done  = conv_done;
		stat.ins_zero   = idx_q == '0;
		stat.ins_less   = lt_s(key_q, rd_q.key);
		stat.all_seen   = all_seen;
		stat.rel_more   = idx_q < count_q;
		stat.rel_ok     = !lt_s(lim_q, rd_q.key);
		stat.pend_valid = pend_v_q;
		stat.out_free   = !out_v_q || m_tready;
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_v_q;
	assign m_tdata   = {out_tag_q, out_pts_q, out_dts_q};
	assign m_tuser   = {out_kf_q, out_sid_q, out_rv_q, out_status_q};
	assign m_tlast   = out_last_q;

endmodule
`default_nettype wire

### rtl/tsfi_ctrl.sv
// controller: sequences classify, convert, insert and release
`default_nettype none
module tsfi_ctrl
	import tsfi_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_tvalid,
	output logic       s_tready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_nxt;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE:     if (s_tvalid) state_nxt = S_CHECK;
			S_CHECK:    state_nxt = stat.go ? S_CONV : S_FINISH;
			S_CONV:     if (stat.conv_done) state_nxt = S_INS_RD;
			S_INS_RD:   state_nxt = stat.ins_zero ? S_INS_WR : S_INS_CMP;
			S_INS_CMP:  state_nxt = stat.ins_less ? S_INS_RD : S_INS_WR;
			S_INS_WR:   state_nxt = stat.all_seen ? S_LIMIT : S_FINISH;
			S_LIMIT:    state_nxt = S_REL_RD;
			S_REL_RD:   state_nxt = stat.rel_more ? S_REL_CHK : S_FINISH;
			S_REL_CHK:  state_nxt = stat.rel_ok ? S_REL_PUSH : S_FINISH;
			S_REL_PUSH: if (!stat.pend_valid || stat.out_free) state_nxt = S_REL_RD;
			S_FINISH:   if (stat.out_free) state_nxt = S_IDLE;
			default:    state_nxt = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			S_CHECK:    cmd.classify  = 1'b1;
			S_CONV:     cmd.key_store = stat.conv_done;
			S_INS_RD:   cmd.ins_read  = !stat.ins_zero;
			S_INS_CMP:  cmd.ins_move  = stat.ins_less;
			S_INS_WR:   cmd.ins_write = 1'b1;
			S_LIMIT:    cmd.lim_calc  = 1'b1;
			S_REL_RD:   cmd.rel_read  = stat.rel_more;
			S_REL_CHK:  cmd.rel_take  = stat.rel_ok;
			S_REL_PUSH: cmd.rel_push  = !stat.pend_valid || stat.out_free;
			S_FINISH:   cmd.finish    = stat.out_free;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### rtl/timestamp_fix_and_interleave_unit.sv
// top level of the timestamp fix and interleave unit
//
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   tdata: decode, present, tag; tuser: stream, keyframe
// m_*      out  m_tvalid/m_tready   tdata: decode, present, tag; tuser: status etc; tlast
// cfg_*    in   cfg_valid/cfg_ready cfg_index selects register, cfg_data value
//
// one item at a time: a rejected or dropped item skips conversion and insert,
// a held one waits on the serial divider of streams 1..3 when it runs,
// the insert moves held entries one at a time and the release walk sends one packet at a time
// the 64-step divider and the hold memory walk set how long an item takes
// reset empties the store at once through its fill count; no clearing pass
// a stalled m_tready holds the result register and stops the release walk
`default_nettype none
module timestamp_fix_and_interleave_unit
	import tsfi_pkg::*;
#(
	parameter int NUM_STREAMS = NUM_STREAMS_DEF,
	parameter int HOLD_DEPTH  = HOLD_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// decode_time[63:0], present_time[127:64], packet_tag[143:128]
	input  wire logic [S_DATA_W-1:0]  s_tdata,
	// stream_id[1:0], is_video_key[2]
	input  wire logic [S_USER_W-1:0]  s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// out_decode_time[63:0], out_present_time[127:64], out_tag[143:128]
	output logic [M_DATA_W-1:0]       m_tdata,
	// item_status[2:0], release_valid[3], released_stream[5:4], out_keyframe[6]
	output logic [M_USER_W-1:0]       m_tuser,
	output logic                      m_tlast,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SCALE_W-1:0]   cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	tsfi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tsfi_dp #(
		.NUM_STREAMS (NUM_STREAMS),
		.HOLD_DEPTH  (HOLD_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_ready (cfg_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

### rtl/tsfi_checker.sv
// port-level checks of the timestamp fix and interleave unit
`default_nettype none
module tsfi_checker
	import tsfi_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [M_DATA_W-1:0] m_tdata,
	input wire logic [M_USER_W-1:0] m_tuser,
	input wire logic                m_tlast
);

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	// a result without a packet closes its run
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[3] |-> m_tlast && m_tdata == '0)
		else $error("empty result not last or not zero");

	// rejected, duplicate and overflow items release nothing
	a_no_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] == ST_REJECT || m_tuser[2:0] == ST_DUP
			|| m_tuser[2:0] == ST_OVERFLOW) |-> !m_tuser[3])
		else $error("release on a failed item");

	// status code stays in its range
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[2] && (m_tuser[1] || m_tuser[0])))
		else $error("status code out of range");

endmodule

bind timestamp_fix_and_interleave_unit tsfi_checker u_tsfi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire
